// ===== hdl/jse_pkg.sv =====
// ============================================================================
// jse_pkg
// Types, constants and byte tables shared by the JSON string escaper.
// ============================================================================
`default_nettype none

package jse_pkg;

    // Room that must remain in the destination before a byte is escaped.
    localparam logic [16:0] ESCAPE_ROOM = 17'd6;
    localparam logic [15:0] CAP_RESET   = 16'd256;

    // Descriptor queue between the front and back parts.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CTRL_LIM  = 8'h20;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PLAIN,
        KIND_PAIR,
        KIND_UNICODE
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] src;
        logic       term;
    } t_desc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       terminator;
    } t_res;

    function automatic t_kind f_classify(input logic [7:0] c);
        t_kind k;
        case (c)
            8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09: k = KIND_PAIR;
            default: k = (c < CTRL_LIM) ? KIND_UNICODE : KIND_PLAIN;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] f_len(input t_kind k);
        logic [2:0] n;
        case (k)
            KIND_PLAIN:   n = 3'd1;
            KIND_PAIR:    n = 3'd2;
            KIND_UNICODE: n = 3'd6;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] f_second(input logic [7:0] c);
        logic [7:0] s;
        case (c)
            8'h08:   s = 8'h62; // b
            8'h0C:   s = 8'h66; // f
            8'h0A:   s = 8'h6E; // n
            8'h0D:   s = 8'h72; // r
            8'h09:   s = 8'h74; // t
            default: s = c;     // quote and backslash repeat themselves
        endcase
        return s;
    endfunction

    function automatic logic [7:0] f_hex(input logic [3:0] d);
        logic [7:0] h;
        h = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (8'h57 + {4'd0, d});
        return h;
    endfunction

    // Byte at position idx of the escape sequence for source byte c.
    function automatic logic [7:0] f_esc_byte(input t_kind k, input logic [7:0] c,
                                              input logic [2:0] idx);
        logic [7:0] b;
        b = c;
        case (k)
            KIND_PAIR: b = (idx == 3'd0) ? CH_BSLASH : f_second(c);
            KIND_UNICODE: begin
                case (idx)
                    3'd0:    b = CH_BSLASH;
                    3'd1:    b = CH_U;
                    3'd2:    b = CH_ZERO;
                    3'd3:    b = CH_ZERO;
                    3'd4:    b = f_hex(c[7:4]);
                    default: b = f_hex(c[3:0]);
                endcase
            end
            default: b = c;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jse_in_if.sv =====
// ============================================================================
// jse_in_if
// Source byte channel: one source byte and its end-of-string flag.
// ============================================================================
`default_nettype none

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_string;

    modport source (output valid, output source_byte, output end_of_string, input ready);
    modport sink   (input valid, input source_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== hdl/jse_out_if.sv =====
// ============================================================================
// jse_out_if
// Escaped byte channel: one output byte with its framing flags.
// ============================================================================
`default_nettype none

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       terminator;

    modport source (output valid, output out_byte, output run_last, output terminator,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input terminator,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/jse_front.sv =====
// ============================================================================
// jse_front
// Accepts source bytes, tracks the string's output count and halt state, and
// turns each byte that it keeps into a descriptor for the serializer.
// ============================================================================
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [15:0] i_capacity,
    input  wire         i_accept,
    input  wire  [7:0]  i_source_byte,
    input  wire         i_end_of_string,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [15:0] r_count, n_count;
    logic        r_halted, n_halted;

    always_comb begin
        logic       cap_nz;
        logic       stop;
        t_kind      kind;
        cap_nz   = (i_capacity != 16'd0);
        stop     = (i_source_byte == CH_NUL) ||
                   (({1'b0, r_count} + ESCAPE_ROOM) >= {1'b0, i_capacity});
        kind     = KIND_NONE;
        n_count  = r_count;
        n_halted = r_halted;
        if (cap_nz && !r_halted) begin
            if (stop) begin
                n_halted = 1'b1;
            end else begin
                kind    = f_classify(i_source_byte);
                n_count = r_count + {13'd0, f_len(kind)};
            end
        end
        if (i_end_of_string) begin
            n_count  = 16'd0;
            n_halted = 1'b0;
        end
        o_desc.kind = kind;
        o_desc.src  = i_source_byte;
        o_desc.term = i_end_of_string && cap_nz;
        o_push      = i_accept && ((kind != KIND_NONE) || o_desc.term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 16'd0;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jse_fifo.sv =====
// ============================================================================
// jse_fifo
// Short descriptor queue that decouples the front from the serializer.
// ============================================================================
`default_nettype none

module jse_fifo
    import jse_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  t_desc        i_data,
    input  wire          i_pop,
    output t_desc        o_head,
    output logic         o_empty,
    output logic         o_full
);

    t_desc              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("descriptor queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("descriptor queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/jse_back.sv =====
// ============================================================================
// jse_back
// Serializer: expands the head descriptor into its output bytes, one per
// cycle while the output is ready, through a registered output stage.
// ============================================================================
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_desc       i_head,
    input  wire         i_empty,
    output logic        o_pop,
    jse_out_if.source   o_out
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    t_res       r_res, n_res;
    logic       load;

    always_comb begin
        logic [2:0] len;
        logic [2:0] total;
        logic       last;
        logic       in_esc;
        len    = f_len(i_head.kind);
        total  = len + {2'd0, i_head.term};
        last   = (r_idx == (total - 3'd1));
        in_esc = (r_idx < len);
        load   = !i_empty && (!r_valid || o_out.ready);
        o_pop  = load && last;

        n_res.out_byte   = in_esc ? f_esc_byte(i_head.kind, i_head.src, r_idx) : CH_NUL;
        n_res.run_last   = last;
        n_res.terminator = !in_esc;

        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = last ? 3'd0 : (r_idx + 3'd1);
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_res.out_byte;
    assign o_out.run_last   = r_res.run_last;
    assign o_out.terminator = r_res.terminator;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= 3'd6)
        else $error("serializer index out of range");

    a_term_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.terminator |-> r_res.run_last && (r_res.out_byte == CH_NUL))
        else $error("terminator not on the final byte of a transaction group");

    a_idx_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 3'd0))
        else $error("serializer index not rewound after a descriptor");

endmodule

`default_nettype wire

// ===== hdl/json_string_escaper.sv =====
// ============================================================================
// json_string_escaper
// Streaming JSON string escaper with an APB-style capacity register.
// ============================================================================
// The block takes one source byte per input transaction and emits its
// JSON-escaped form, one byte per output transaction, with run_last set on
// the final byte caused by each input and terminator set on the closing NUL
// of a string. A front part accepts bytes at one per cycle, tracks the
// output count against the capacity register and writes a descriptor into a
// four-entry queue; a back part expands each descriptor through a
// registered output stage. A pass-through byte yields one output byte, a
// two-character escape two, a \u00xx escape six, and the end-of-string item
// adds one for the terminator; the serializer's one byte per cycle while
// output is ready sets the sustained rate, so plain text streams at one
// item per cycle and escapes stall the input only once the queue is full.
// Bytes that are dropped (after a NUL, or once the capacity limit is met)
// produce no output transaction. The capacity register sits at byte address
// 0, resets to 256 and should be written only while the block is idle.
// ============================================================================
`default_nettype none

module json_string_escaper
    import jse_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    jse_in_if.sink      i_in,
    jse_out_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_capacity;
    logic        cfg_write;
    logic        accept;
    logic        push;
    t_desc       push_desc;
    t_desc       head;
    logic        q_empty;
    logic        q_full;
    logic        pop;

    // Only one register exists, so every word of the small address window
    // decodes to it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00
                       || paddr[1:0] != 2'b00);
    assign prdata    = {16'd0, r_capacity};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[15:0];
        end
    end

    // The input side only waits on queue space, never on the output side.
    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && i_in.ready;

    jse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_capacity      (r_capacity),
        .i_accept        (accept),
        .i_source_byte   (i_in.source_byte),
        .i_end_of_string (i_in.end_of_string),
        .o_push          (push),
        .o_desc          (push_desc)
    );

    jse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    jse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== verif/json_string_escaper_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// json_string_escaper_tb
// Self-checking testbench for the streaming JSON string escaper.
// ============================================================================
// Source bytes are driven on the input channel, and a behavioral predictor
// works out the escaped bytes that each accepted transaction must produce.
// Every output transaction is compared field by field with the oldest
// prediction. The capacity register is rewritten between phases, only while
// the block is idle. The directed tests cover each escape class, the NUL stop,
// the capacity limits and a capacity change in the middle of a string.
// Random strings then run under bursty input and stalling output.
// ============================================================================
`default_nettype none

module json_string_escaper_tb;
    import jse_pkg::*;

    // Address of the capacity register on the configuration port.
    localparam logic [1:0] ADDR_OUTPUT_CAPACITY = 2'd0;

    // Control characters that have a short two-character escape.
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;

    // Cycles to let pass once the last result is in, so the block is quiet
    // before the capacity register is rewritten.
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    jse_in_if  in_if ();
    jse_out_if out_if ();

    json_string_escaper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a copy of the capacity register and the per-string
    // bookkeeping that decides when escaping stops.
    logic [15:0] capacity_model;
    logic [15:0] written_model;
    logic        halted_model;

    // Escaped bytes still owed by the block, oldest first.
    t_res escaped_q[$];

    int err_count;
    int bytes_sent;
    int results_seen;
    int cap_writes;

    // Pacing of both channels.
    t_rx_mode rx_mode;
    int       hold_off;
    bit       gaps_on;
    int       burst_left;

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d escaped bytes still expected.", escaped_q.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + 8'(d)) : (8'h61 + 8'(d) - 8'd10);
    endfunction

    task automatic queue_escaped(input logic [7:0] b, input logic term);
        t_res r;
        r.out_byte   = b;
        r.run_last   = 1'b0;
        r.terminator = term;
        escaped_q.push_back(r);
    endtask

    // Appends the escaped form of one source byte.
    task automatic expand_byte(input logic [7:0] c);
        logic [7:0] second;
        second = CH_NUL;
        case (c)
            CH_QUOTE, CH_BSLASH: second = c;
            CTL_BS:  second = "b";
            CTL_FF:  second = "f";
            CTL_LF:  second = "n";
            CTL_CR:  second = "r";
            CTL_TAB: second = "t";
            default: second = CH_NUL;
        endcase
        if (second != CH_NUL) begin
            queue_escaped(CH_BSLASH, 1'b0);
            queue_escaped(second, 1'b0);
        end else if (c < CTRL_LIM) begin
            queue_escaped(CH_BSLASH, 1'b0);
            queue_escaped(CH_U, 1'b0);
            queue_escaped(CH_ZERO, 1'b0);
            queue_escaped(CH_ZERO, 1'b0);
            queue_escaped(hex_digit(c[7:4]), 1'b0);
            queue_escaped(hex_digit(c[3:0]), 1'b0);
        end else begin
            queue_escaped(c, 1'b0);
        end
    endtask

    // Works out everything that one accepted source byte must produce.
    task automatic predict_escape(input logic [7:0] c, input logic eos);
        int base_sz;
        base_sz = escaped_q.size();
        if (capacity_model != 16'd0 && !halted_model) begin
            // A NUL ends the string early; so does running short of room
            // for the longest escape.
            if (c == CH_NUL ||
                ({1'b0, written_model} + ESCAPE_ROOM >= {1'b0, capacity_model})) begin
                halted_model = 1'b1;
            end else begin
                expand_byte(c);
                written_model = written_model + 16'(escaped_q.size() - base_sz);
            end
        end
        if (eos) begin
            // With zero capacity even the terminator is suppressed.
            if (capacity_model != 16'd0)
                queue_escaped(CH_NUL, 1'b1);
            written_model = 16'd0;
            halted_model  = 1'b0;
        end
        if (escaped_q.size() > base_sz)
            escaped_q[escaped_q.size() - 1].run_last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic report_miss(input string what, input t_res want, input t_res got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%t: %s: expected byte %h last %b term %b, got byte %h last %b term %b",
                     $realtime, what, want.out_byte, want.run_last, want.terminator,
                     got.out_byte, got.run_last, got.terminator);
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        t_res got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            got.out_byte   = out_if.out_byte;
            got.run_last   = out_if.run_last;
            got.terminator = out_if.terminator;
            if (escaped_q.size() == 0) begin
                want = '0;
                report_miss("unexpected transaction", want, got);
            end else begin
                want = escaped_q.pop_front();
                if (got !== want)
                    report_miss("mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random or pattern stalls, plus long hold-offs on request.
    // ------------------------------------------------------------------------
    initial begin : output_pacing
        int tick;
        tick = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                out_if.ready <= 1'b0;
                hold_off--;
            end else begin
                case (rx_mode)
                    RX_RANDOM:  out_if.ready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN: out_if.ready <= ((tick % 5) > 1);
                    default:    out_if.ready <= 1'b1;
                endcase
            end
            tick++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender and configuration tasks.
    // ------------------------------------------------------------------------
    task automatic idle_input(input int n);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Offers one source byte and waits for the transaction, then paces the
    // next one in bursts with gaps when gaps are enabled.
    task automatic send_byte(input logic [7:0] c, input logic eos);
        @(negedge i_clk);
        in_if.valid         <= 1'b1;
        in_if.source_byte   <= c;
        in_if.end_of_string <= eos;
        do @(posedge i_clk); while (!in_if.ready);
        predict_escape(c, eos);
        bytes_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                idle_input($urandom_range(1, 6));
                burst_left = $urandom_range(0, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Waits until every predicted byte has come out, then lets the block
    // sit idle for the settle period.
    task automatic drain_block();
        idle_input(1);
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the capacity register and reads it back.
    task automatic write_capacity(input logic [15:0] value);
        t_res want;
        t_res got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OUTPUT_CAPACITY;
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        capacity_model = value;
        cap_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== value) begin
            want = '0;
            got  = '0;
            want.out_byte = value[7:0];
            got.out_byte  = prdata[7:0];
            report_miss("capacity readback", want, got);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Picks a source byte, weighted toward the bytes that need escaping.
    function automatic logic [7:0] pick_source_byte();
        int r;
        logic [7:0] pairs [7];
        pairs = '{CH_QUOTE, CH_BSLASH, CTL_BS, CTL_FF, CTL_LF, CTL_CR, CTL_TAB};
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(8'h20, 8'h7E));
        if (r < 68) return pairs[$urandom_range(0, 6)];
        if (r < 82) return 8'($urandom_range(1, 31));
        if (r < 96) return 8'($urandom_range(8'h7F, 8'hFF));
        return CH_NUL;
    endfunction

    task automatic send_random_string(input int len);
        for (int i = 0; i < len; i++)
            send_byte(pick_source_byte(), i == len - 1);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Every escape class in one string at the reset capacity, and a lone
    // control byte that ends a string and so produces the most results.
    task automatic test_escape_classes();
        logic [7:0] line [12];
        line = '{CH_QUOTE, CH_BSLASH, CTL_BS, CTL_FF, CTL_LF, CTL_CR, CTL_TAB,
                 8'h01, 8'h1F, 8'h20, 8'h7F, 8'hFF};
        foreach (line[i])
            send_byte(line[i], i == 11);
        send_byte(8'h1B, 1'b1);
        drain_block();
    endtask

    // A NUL halts the string: later bytes vanish but the terminator comes.
    task automatic test_nul_stop();
        send_byte("a", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte("b", 1'b0);
        send_byte(8'h80, 1'b1);
        drain_block();
    endtask

    // Zero capacity, a capacity that leaves room for exactly one byte, and
    // one too small for any byte at all.
    task automatic test_capacity_edges();
        write_capacity(16'd0);
        send_byte("q", 1'b0);
        send_byte(8'h01, 1'b1);
        drain_block();
        write_capacity(16'd7);
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
        drain_block();
        write_capacity(16'd1);
        send_byte(CTL_LF, 1'b1);
        drain_block();
    endtask

    // Shrinks the capacity below the count already written: later bytes are
    // dropped and the terminator still comes.
    task automatic test_capacity_midstring();
        write_capacity(16'hFFFF);
        send_byte(8'h02, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte("z", 1'b0);
        drain_block();
        write_capacity(16'd8);
        send_byte("y", 1'b0);
        send_byte(8'h05, 1'b1);
        drain_block();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering escape-heavy bytes, so the block must stall its input.
    task automatic test_output_backpressure();
        write_capacity(16'd512);
        gaps_on  = 1'b0;
        rx_mode  = RX_FREE;
        hold_off = 200;
        for (int i = 0; i < 30; i++)
            send_byte((i % 3 == 0) ? 8'h01 : pick_source_byte(), i == 29);
        drain_block();
    endtask

    // Random strings over several capacity settings with varied pacing.
    task automatic test_random_strings();
        int sent;
        logic [15:0] cap;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       cap = 16'hFFFF;
                1:       cap = 16'd0;
                2:       cap = 16'($urandom_range(7, 24));
                3:       cap = CAP_RESET;
                4:       cap = 16'($urandom_range(25, 80));
                default: cap = 16'($urandom_range(8, 16));
            endcase
            write_capacity(cap);
            // The first phase runs with neither side idling.
            gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_mode = (phase == 0) ? RX_FREE : t_rx_mode'($urandom_range(0, 2));
            sent = 0;
            while (sent < 24) begin
                // Mostly short strings; now and then a long one that can run
                // into the capacity limit.
                int len;
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                send_random_string(len);
                sent += len;
            end
            drain_block();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.source_byte   = 8'h00;
        in_if.end_of_string = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = ADDR_OUTPUT_CAPACITY;
        pwdata              = 32'd0;
        rx_mode             = RX_FREE;
        hold_off            = 0;
        gaps_on             = 1'b0;
        burst_left          = 0;
        err_count           = 0;
        bytes_sent          = 0;
        results_seen        = 0;
        cap_writes          = 0;
        capacity_model      = CAP_RESET;
        written_model       = 16'd0;
        halted_model        = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // The directed tests run with a stalling receiver.
        rx_mode = RX_PATTERN;
        test_escape_classes();
        test_nul_stop();
        test_capacity_edges();
        test_capacity_midstring();
        test_output_backpressure();
        test_random_strings();

        if (escaped_q.size() != 0)
            err_count++;

        $display("Sent %0d source bytes and checked %0d escaped bytes over %0d capacity writes.",
                 bytes_sent, results_seen, cap_writes);
        $display("Covered all escape classes, NUL stops, capacity limits and output backpressure.");
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures.", err_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/jse_pkg.sv
hdl/jse_in_if.sv
hdl/jse_out_if.sv
hdl/jse_front.sv
hdl/jse_fifo.sv
hdl/jse_back.sv
hdl/json_string_escaper.sv
verif/json_string_escaper_tb.sv
